// File: rtl/quoted_array_literal_parser_assert.svh
// ----------------------------------------------------------------------------
// Quoted array literal parser assertion macros
// Shared assertion forms for the parser's checks.
// ----------------------------------------------------------------------------
`ifndef QUOTED_ARRAY_LITERAL_PARSER_ASSERT_SVH
`define QUOTED_ARRAY_LITERAL_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QALP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define QALP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/qalp_pkg.sv
// ----------------------------------------------------------------------------
// Quoted array literal parser package
// Phase codes, result codes, character constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package qalp_pkg;

  localparam int PhaseW = 3;

  localparam logic [PhaseW-1:0] PH_START       = 3'd0;
  localparam logic [PhaseW-1:0] PH_OPENED      = 3'd1;
  localparam logic [PhaseW-1:0] PH_ELEM_START  = 3'd2;
  localparam logic [PhaseW-1:0] PH_UNQUOTED    = 3'd3;
  localparam logic [PhaseW-1:0] PH_QUOTED      = 3'd4;
  localparam logic [PhaseW-1:0] PH_ESCAPE      = 3'd5;
  localparam logic [PhaseW-1:0] PH_AFTER_QUOTE = 3'd6;
  localparam logic [PhaseW-1:0] PH_CLOSED      = 3'd7;

  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_ELEM_END  = 2'd1;
  localparam logic [1:0] KIND_ARRAY_END = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  localparam logic [2:0] ERR_OPEN_EXPECTED   = 3'd0;
  localparam logic [2:0] ERR_BACKSLASH_END   = 3'd1;
  localparam logic [2:0] ERR_MISSING_QUOTE   = 3'd2;
  localparam logic [2:0] ERR_SEP_EXPECTED    = 3'd3;
  localparam logic [2:0] ERR_MISSING_CLOSE   = 3'd4;
  localparam logic [2:0] ERR_UNEXPECTED_OPEN = 3'd5;
  localparam logic [2:0] ERR_GARBAGE         = 3'd6;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_OPEN      = 8'h7B;
  localparam logic [7:0] CH_CLOSE     = 8'h7D;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] element_byte;
    logic [2:0] error_code;
  } qalp_result_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              hit;
    qalp_result_t      res;
  } qalp_dec_t;

endpackage

`default_nettype wire

// File: rtl/qalp_decode.sv
// ----------------------------------------------------------------------------
// Quoted array literal parser byte decoder
// Decides the next phase and the optional result for one text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module qalp_decode
  import qalp_pkg::*;
(
  input  wire logic [PhaseW-1:0] phase,
  input  wire logic [7:0]        text_byte,
  output qalp_dec_t              dec
);

  function automatic qalp_dec_t emit(input logic [PhaseW-1:0] ph, input logic [1:0] kind,
                                     input logic [7:0] b);
    qalp_dec_t d;
    d.phase            = ph;
    d.hit              = 1'b1;
    d.res.result_kind  = kind;
    d.res.element_byte = b;
    d.res.error_code   = ERR_OPEN_EXPECTED;
    return d;
  endfunction

  function automatic qalp_dec_t fail(input logic [2:0] err);
    qalp_dec_t d;
    d.phase            = PH_START;
    d.hit              = 1'b1;
    d.res.result_kind  = KIND_ERROR;
    d.res.element_byte = CH_NUL;
    d.res.error_code   = err;
    return d;
  endfunction

  function automatic qalp_dec_t quiet(input logic [PhaseW-1:0] ph);
    qalp_dec_t d;
    d.phase            = ph;
    d.hit              = 1'b0;
    d.res.result_kind  = KIND_BYTE;
    d.res.element_byte = CH_NUL;
    d.res.error_code   = ERR_OPEN_EXPECTED;
    return d;
  endfunction

  function automatic qalp_dec_t elem_start(input logic [7:0] c);
    qalp_dec_t d;
    if (c == CH_QUOTE) begin
      d = quiet(PH_QUOTED);
    end else if (c == CH_NUL) begin
      d = fail(ERR_MISSING_CLOSE);
    end else if (c == CH_OPEN) begin
      d = fail(ERR_UNEXPECTED_OPEN);
    end else if (c == CH_COMMA) begin
      d = emit(PH_ELEM_START, KIND_ELEM_END, CH_NUL);
    end else if (c == CH_CLOSE) begin
      d = emit(PH_CLOSED, KIND_ELEM_END, CH_NUL);
    end else begin
      d = emit(PH_UNQUOTED, KIND_BYTE, c);
    end
    return d;
  endfunction

  always_comb begin
    case (phase)
      PH_OPENED: begin
        if (text_byte == CH_CLOSE) dec = quiet(PH_CLOSED);
        else                       dec = elem_start(text_byte);
      end
      PH_ELEM_START: begin
        dec = elem_start(text_byte);
      end
      PH_UNQUOTED: begin
        if (text_byte == CH_COMMA)      dec = emit(PH_ELEM_START, KIND_ELEM_END, CH_NUL);
        else if (text_byte == CH_CLOSE) dec = emit(PH_CLOSED, KIND_ELEM_END, CH_NUL);
        else if (text_byte == CH_NUL)   dec = fail(ERR_MISSING_CLOSE);
        else                            dec = emit(PH_UNQUOTED, KIND_BYTE, text_byte);
      end
      PH_QUOTED: begin
        if (text_byte == CH_QUOTE)          dec = quiet(PH_AFTER_QUOTE);
        else if (text_byte == CH_BACKSLASH) dec = quiet(PH_ESCAPE);
        else if (text_byte == CH_NUL)       dec = fail(ERR_MISSING_QUOTE);
        else                                dec = emit(PH_QUOTED, KIND_BYTE, text_byte);
      end
      PH_ESCAPE: begin
        if (text_byte == CH_NUL) dec = fail(ERR_BACKSLASH_END);
        else                     dec = emit(PH_QUOTED, KIND_BYTE, text_byte);
      end
      PH_AFTER_QUOTE: begin
        if (text_byte == CH_COMMA)      dec = emit(PH_ELEM_START, KIND_ELEM_END, CH_NUL);
        else if (text_byte == CH_CLOSE) dec = emit(PH_CLOSED, KIND_ELEM_END, CH_NUL);
        else                            dec = fail(ERR_SEP_EXPECTED);
      end
      PH_CLOSED: begin
        if (text_byte == CH_NUL) dec = emit(PH_START, KIND_ARRAY_END, CH_NUL);
        else                     dec = fail(ERR_GARBAGE);
      end
      default: begin
        if (text_byte == CH_NUL)       dec = emit(PH_START, KIND_ARRAY_END, CH_NUL);
        else if (text_byte == CH_OPEN) dec = quiet(PH_OPENED);
        else                           dec = fail(ERR_OPEN_EXPECTED);
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/quoted_array_literal_parser.sv
// ----------------------------------------------------------------------------
// Quoted array literal parser
// Streams a brace-delimited array literal and emits decoded element bytes,
// element ends, the array end or an error code.
// ----------------------------------------------------------------------------
// The input channel takes one text byte per item; a zero byte ends the text.
// The output channel gives at most one result item per input item: a decoded
// element byte, an element end, an array end or an error with its code.
// Both channels use valid and stall; an item moves at an edge where valid is
// high and stall is low.
// An accepted byte enters an input register and is decided by the byte decoder
// against the phase register once the output register is free; its result is
// then loaded into the output register, from which it is offered. A byte can
// be accepted every cycle unless the input register holds a byte that waits
// for the output register.
// When the receiver stalls with a result pending, the output register holds
// and the input register fills; in_stall rises only once both are occupied.
// Bytes that give no result pass through without using the output register.
// Reset clears both valid flags and returns the parser to its start phase.
// After an error or an array end the parser is back at its start phase.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_array_literal_parser
  import qalp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_result_kind,
  output logic [7:0]      out_element_byte,
  output logic [2:0]      out_error_code
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [7:0]        s1_byte_r;
  logic [PhaseW-1:0] phase_r;
  logic [PhaseW-1:0] phase_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  qalp_result_t      out_res_r;
  logic              out_free;
  logic              s1_go;
  qalp_dec_t         dec;

  qalp_decode u_decode (
    .phase     (phase_r),
    .text_byte (s1_byte_r),
    .dec       (dec)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_comb begin
    s1_valid_nxt = in_stall ? s1_valid_r : in_valid;
    phase_nxt    = s1_go ? dec.phase : phase_r;
    if (out_free) begin
      out_valid_nxt = s1_go && dec.hit;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_START;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_text_byte;
    end
    if (out_free) begin
      out_res_r <= dec.res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_res_r.result_kind;
  assign out_element_byte = out_res_r.element_byte;
  assign out_error_code   = out_res_r.error_code;

`include "quoted_array_literal_parser_assert.svh"

  `QALP_ASSERT_NEXT(a_err_restarts, s1_go && dec.hit && dec.res.result_kind == KIND_ERROR,
    phase_r == PH_START, "error result did not return parser to start")
  `QALP_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_r && out_valid_r,
    "input stalled without a held item")
  `QALP_ASSERT_NEXT(a_out_drains, out_valid_r && !out_stall && !s1_valid_r, !out_valid_r,
    "result repeated after being taken")
  `QALP_ASSERT_NEXT(a_phase_holds, !s1_go, phase_r == $past(phase_r),
    "phase changed without a decided item")

endmodule

`default_nettype wire

// File: test/quoted_array_literal_parser_test.sv
// ----------------------------------------------------------------------------
// Quoted array literal parser testbench
// A directed set of literals covers the empty text, the brace pair, quoted and
// unquoted elements, escapes and every error. Random well-formed literals,
// broken literals and noise follow. Each accepted byte is decoded by a local
// parser model, and every result item is checked field by field against it.
// The sender works in bursts and the receiver stalls in changing patterns,
// with long hold-offs that fill the block and stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_array_literal_parser_test;
  import qalp_pkg::*;

  localparam int RandomBytes = 950;
  localparam int IdleLimit   = 1000;
  localparam int HoldCycles  = 80;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic [7:0] out_element_byte;
  logic [2:0] out_error_code;

  quoted_array_literal_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_element_byte (out_element_byte),
    .out_error_code   (out_error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]        text_bytes[$];
  qalp_result_t      expected_results[$];
  logic [PhaseW-1:0] literal_phase = PH_START;
  int                mismatch_count = 0;
  int                bytes_taken = 0;
  int                idle_cycles = 0;
  logic              in_taken = 1'b0;
  logic              long_hold = 1'b0;

  task automatic parse_text_byte(input logic [7:0] c);
    qalp_result_t      r;
    logic              hit;
    logic [PhaseW-1:0] nxt;
    r = '0;
    hit = 1'b1;
    nxt = literal_phase;
    case (literal_phase)
      PH_OPENED, PH_ELEM_START: begin
        if (literal_phase == PH_OPENED && c == CH_CLOSE) begin
          hit = 1'b0;
          nxt = PH_CLOSED;
        end else if (c == CH_QUOTE) begin
          hit = 1'b0;
          nxt = PH_QUOTED;
        end else if (c == CH_NUL) begin
          r.result_kind = KIND_ERROR;
          r.error_code = ERR_MISSING_CLOSE;
          nxt = PH_START;
        end else if (c == CH_OPEN) begin
          r.result_kind = KIND_ERROR;
          r.error_code = ERR_UNEXPECTED_OPEN;
          nxt = PH_START;
        end else if (c == CH_COMMA || c == CH_CLOSE) begin
          r.result_kind = KIND_ELEM_END;
          nxt = (c == CH_COMMA) ? PH_ELEM_START : PH_CLOSED;
        end else begin
          r.result_kind = KIND_BYTE;
          r.element_byte = c;
          nxt = PH_UNQUOTED;
        end
      end
      PH_UNQUOTED: begin
        if (c == CH_COMMA || c == CH_CLOSE) begin
          r.result_kind = KIND_ELEM_END;
          nxt = (c == CH_COMMA) ? PH_ELEM_START : PH_CLOSED;
        end else if (c == CH_NUL) begin
          r.result_kind = KIND_ERROR;
          r.error_code = ERR_MISSING_CLOSE;
          nxt = PH_START;
        end else begin
          r.result_kind = KIND_BYTE;
          r.element_byte = c;
        end
      end
      PH_QUOTED: begin
        if (c == CH_QUOTE) begin
          hit = 1'b0;
          nxt = PH_AFTER_QUOTE;
        end else if (c == CH_BACKSLASH) begin
          hit = 1'b0;
          nxt = PH_ESCAPE;
        end else if (c == CH_NUL) begin
          r.result_kind = KIND_ERROR;
          r.error_code = ERR_MISSING_QUOTE;
          nxt = PH_START;
        end else begin
          r.result_kind = KIND_BYTE;
          r.element_byte = c;
        end
      end
      PH_ESCAPE: begin
        if (c == CH_NUL) begin
          r.result_kind = KIND_ERROR;
          r.error_code = ERR_BACKSLASH_END;
          nxt = PH_START;
        end else begin
          r.result_kind = KIND_BYTE;
          r.element_byte = c;
          nxt = PH_QUOTED;
        end
      end
      PH_AFTER_QUOTE: begin
        if (c == CH_COMMA || c == CH_CLOSE) begin
          r.result_kind = KIND_ELEM_END;
          nxt = (c == CH_COMMA) ? PH_ELEM_START : PH_CLOSED;
        end else begin
          r.result_kind = KIND_ERROR;
          r.error_code = ERR_SEP_EXPECTED;
          nxt = PH_START;
        end
      end
      PH_CLOSED: begin
        nxt = PH_START;
        if (c == CH_NUL) begin
          r.result_kind = KIND_ARRAY_END;
        end else begin
          r.result_kind = KIND_ERROR;
          r.error_code = ERR_GARBAGE;
        end
      end
      default: begin
        if (c == CH_NUL) begin
          r.result_kind = KIND_ARRAY_END;
          nxt = PH_START;
        end else if (c == CH_OPEN) begin
          hit = 1'b0;
          nxt = PH_OPENED;
        end else begin
          r.result_kind = KIND_ERROR;
          r.error_code = ERR_OPEN_EXPECTED;
          nxt = PH_START;
        end
      end
    endcase
    literal_phase = nxt;
    if (hit) begin
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  task automatic add_text(input string s, input logic terminate);
    foreach (s[i]) begin
      text_bytes.insert(text_bytes.size(), s[i]);
    end
    if (terminate) begin
      text_bytes.insert(text_bytes.size(), CH_NUL);
    end
  endtask

  // Mostly well-formed literals with random content; the rest are cut short
  // at a random point, plain empty texts, or raw noise.
  task automatic add_random_literal();
    logic [7:0] lit[$];
    logic [7:0] c;
    int         style;
    int         n_elem;
    int         len;
    int         cut;
    style = $urandom_range(0, 19);
    if (style < 2) begin
      repeat ($urandom_range(1, 6)) begin
        text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
      end
      return;
    end
    if (style == 2) begin
      text_bytes.insert(text_bytes.size(), CH_NUL);
      return;
    end
    lit.insert(lit.size(), CH_OPEN);
    n_elem = $urandom_range(0, 4);
    for (int e = 0; e < n_elem; e++) begin
      if (e > 0) begin
        lit.insert(lit.size(), CH_COMMA);
      end
      len = $urandom_range(0, 5);
      if ($urandom_range(0, 1) == 1) begin
        lit.insert(lit.size(), CH_QUOTE);
        repeat (len) begin
          c = 8'($urandom_range(1, 255));
          if (c == CH_QUOTE || c == CH_BACKSLASH || $urandom_range(0, 7) == 0) begin
            lit.insert(lit.size(), CH_BACKSLASH);
          end
          lit.insert(lit.size(), c);
        end
        lit.insert(lit.size(), CH_QUOTE);
      end else begin
        for (int k = 0; k < len; k++) begin
          do begin
            c = 8'($urandom_range(1, 255));
          end while (c == CH_COMMA || c == CH_CLOSE ||
                     (k == 0 && (c == CH_QUOTE || c == CH_OPEN)));
          lit.insert(lit.size(), c);
        end
      end
    end
    lit.insert(lit.size(), CH_CLOSE);
    lit.insert(lit.size(), CH_NUL);
    if (style < 6) begin
      cut = $urandom_range(1, lit.size() - 1);
      while (lit.size() > cut) begin
        lit.delete(lit.size() - 1);
      end
      lit.insert(lit.size(), style == 3 ? CH_NUL : 8'($urandom_range(0, 255)));
    end
    foreach (lit[i]) begin
      text_bytes.insert(text_bytes.size(), lit[i]);
    end
  endtask

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    logic       nv;
    logic [7:0] nb;
    nv = 1'b0;
    nb = in_text_byte;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (gap_left > 0 && !long_hold) begin
        gap_left--;
      end else if (text_bytes.size() > 0) begin
        nv = 1'b1;
        nb = text_bytes.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      in_valid <= nv;
      in_text_byte <= nb;
    end
  end

  // Receiver: stall pattern changes now and then, with two long hold-offs.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          hold_left = 0;
  int          holds_done = 0;

  always @(negedge clk) begin
    logic stall_next;
    stall_next = 1'b0;
    if (!rst_n) begin
      out_stall <= 1'b0;
      long_hold <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < 2 &&
          bytes_taken >= (holds_done == 0 ? 200 : 600)) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 60);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:  stall_next = 1'b0;
          STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
          default:     stall_next = ~out_stall;
        endcase
      end
      out_stall <= stall_next;
      long_hold <= (hold_left > 0);
    end
  end

  // Monitor: decodes accepted bytes and checks accepted results.
  always @(posedge clk) begin
    qalp_result_t got;
    qalp_result_t want;
    logic         moved;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      moved = 1'b0;
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got.result_kind = out_result_kind;
        got.element_byte = out_element_byte;
        got.error_code = out_error_code;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d byte %02h code %0d", $time,
                   got.result_kind, got.element_byte, got.error_code);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.result_kind !== want.result_kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time,
                     want.result_kind, got.result_kind);
            mismatch_count++;
          end
          if (got.element_byte !== want.element_byte) begin
            $display("%0t: element_byte expected %02h actual %02h", $time,
                     want.element_byte, got.element_byte);
            mismatch_count++;
          end
          if (got.error_code !== want.error_code) begin
            $display("%0t: error_code expected %0d actual %0d", $time,
                     want.error_code, got.error_code);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        parse_text_byte(in_text_byte);
        bytes_taken++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int directed_count;
    text_bytes.insert(text_bytes.size(), CH_NUL);
    text_bytes.insert(text_bytes.size(), 8'hFF);
    add_text("{}", 1'b1);
    add_text("{}a", 1'b0);
    add_text("{a{\",\"\\\"\",}", 1'b1);
    add_text("{\"\\", 1'b1);
    add_text("{\"", 1'b1);
    add_text("{\"\"x", 1'b0);
    add_text("{{", 1'b0);
    add_text("{a", 1'b1);
    add_text("{", 1'b1);
    directed_count = text_bytes.size();
    while (text_bytes.size() < directed_count + RandomBytes) begin
      add_random_literal();
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (text_bytes.size() > 0 || in_valid) @(negedge clk);
    while (expected_results.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/qalp_pkg.sv
rtl/qalp_decode.sv
rtl/quoted_array_literal_parser.sv
test/quoted_array_literal_parser_test.sv
